[sv/srt_pkg.sv]
package srt_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_CHECK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [3:0] ST_INSERTED  = 4'd0;
	localparam logic [3:0] ST_TOO_LONG  = 4'd1;
	localparam logic [3:0] ST_FULL      = 4'd2;
	localparam logic [3:0] ST_WRAP      = 4'd3;
	localparam logic [3:0] ST_DUPLICATE = 4'd4;
	localparam logic [3:0] ST_OVERLAP   = 4'd5;
	localparam logic [3:0] ST_CONTIG    = 4'd6;
	localparam logic [3:0] ST_GAP       = 4'd7;
	localparam logic [3:0] ST_CHAIN_OVL = 4'd8;
	localparam logic [3:0] ST_CLEARED   = 4'd9;

	localparam logic [15:0] MAX_LEN_RST = 16'd1500;

	// broadcast from the control to every cell
	typedef struct packed {
		logic        upd;
		logic [31:0] seq;
		logic [15:0] len;
		logic [32:0] new_end;
	} cell_ctl_t;

	// per-cell compare results
	typedef struct packed {
		logic below;
		logic early_ovl;
		logic dup;
		logic later_ovl;
		logic gap;
		logic chain_ovl;
	} cell_flags_t;

endpackage

[sv/srt_cell.sv]
module srt_cell (
	input  logic                clk,
	input  srt_pkg::cell_ctl_t  ctl,
	input  logic                occ,
	input  logic [31:0]         left_seq,
	input  logic [15:0]         left_len,
	input  logic                left_below,
	input  logic [31:0]         right_seq,
	input  logic                right_occ,
	output logic [31:0]         seq,
	output logic [15:0]         len,
	output srt_pkg::cell_flags_t flags
);

	logic [31:0] seq_q;
	logic [15:0] len_q;
	logic [32:0] end_c;
	logic        below;
	logic        first_ge;
	logic        ins_here;

	assign end_c    = {1'b0, seq_q} + {17'b0, len_q};
	assign below    = occ && (seq_q < ctl.seq);
	assign first_ge = occ && !below && left_below;
	assign ins_here = !below && left_below;

	always_comb begin
		flags.below     = below;
		flags.early_ovl = below && (end_c > {1'b0, ctl.seq});
		flags.dup       = first_ge && (seq_q == ctl.seq);
		flags.later_ovl = first_ge && ({1'b0, seq_q} < ctl.new_end);
		flags.gap       = right_occ && (end_c < {1'b0, right_seq});
		flags.chain_ovl = right_occ && (end_c > {1'b0, right_seq});
	end

	// take the new segment at the insert point, the left neighbor above it
	always_ff @(posedge clk) begin
		if (ctl.upd && !below) begin
			if (ins_here) begin
				seq_q <= ctl.seq;
				len_q <= ctl.len;
			end else begin
				seq_q <= left_seq;
				len_q <= left_len;
			end
		end
	end

	assign seq = seq_q;
	assign len = len_q;

endmodule

[sv/segment_reassembly_table.sv]
// A request is captured into the s1 registers; its result is written to the
// output registers when it fires. The cell row compares and shifts when the
// request fires; in_stall holds off the next request until then.
// The output register holds a result while the next request is taken.
// Reset (arst_n low) empties the table, zeroes the byte total and sets
// max_len_q to 1500; stored descriptors are not cleared.
module segment_reassembly_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] seq_start,
	input  logic [15:0] seg_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [5:0]  entry_total,
	output logic [20:0] byte_total
);

	localparam int N = srt_pkg::MAX_ENTRIES;

	logic [15:0]    max_len_q;
	logic           valid_s1;
	logic [1:0]     mode_s1;
	logic [31:0]    seq_s1;
	logic [15:0]    len_s1;
	srt_pkg::cnt_t  count_q;
	logic [21:0]    bytes_q;
	logic           out_valid_q;
	logic [3:0]     status_q;
	logic [5:0]     total_q;
	logic [20:0]    byte_total_q;

	srt_pkg::cell_ctl_t   ctl;
	srt_pkg::cell_flags_t flags [N];
	logic [31:0]          cseq [N];
	logic [15:0]          clen [N];
	logic [N-1:0]         occ;
	logic [N-1:0]         early_v, dup_v, later_v, gap_v, covl_v, pair_v, first_v;

	logic           fire;
	logic [3:0]     st_c;
	logic           ins_ok;
	srt_pkg::cnt_t  count_d;
	logic [21:0]    bytes_d;

	assign fire = valid_s1 && (!out_valid_q || !out_stall);

	always_comb begin
		ctl.upd     = fire && ins_ok;
		ctl.seq     = seq_s1;
		ctl.len     = len_s1;
		ctl.new_end = {1'b0, seq_s1} + {17'b0, len_s1};
	end

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			logic [31:0] l_seq;
			logic [15:0] l_len;
			logic        l_below;
			logic [31:0] r_seq;
			logic        r_occ;

			assign occ[i] = count_q > srt_pkg::cnt_t'(i);

			if (i == 0) begin : g_first
				assign l_seq   = '0;
				assign l_len   = '0;
				assign l_below = 1'b1;
			end else begin : g_mid
				assign l_seq   = cseq[i-1];
				assign l_len   = clen[i-1];
				assign l_below = flags[i-1].below;
			end

			if (i == N - 1) begin : g_last
				assign r_seq = '0;
				assign r_occ = 1'b0;
			end else begin : g_inner
				assign r_seq = cseq[i+1];
				assign r_occ = occ[i+1];
			end

			srt_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.occ         (occ[i]),
				.left_seq    (l_seq),
				.left_len    (l_len),
				.left_below  (l_below),
				.right_seq   (r_seq),
				.right_occ   (r_occ),
				.seq         (cseq[i]),
				.len         (clen[i]),
				.flags       (flags[i])
			);

			assign early_v[i] = flags[i].early_ovl;
			assign dup_v[i]   = flags[i].dup;
			assign later_v[i] = flags[i].later_ovl;
			assign gap_v[i]   = flags[i].gap;
			assign covl_v[i]  = flags[i].chain_ovl;
		end
	endgenerate

	// isolate the lowest mismatching adjacent pair
	assign pair_v  = gap_v | covl_v;
	assign first_v = pair_v & (~pair_v + N'(1));

	always_comb begin
		st_c    = srt_pkg::ST_CONTIG;
		ins_ok  = 1'b0;
		count_d = count_q;
		bytes_d = bytes_q;
		case (mode_s1)
			srt_pkg::MODE_INSERT: begin
				if (len_s1 > max_len_q)
					st_c = srt_pkg::ST_TOO_LONG;
				else if (count_q >= srt_pkg::cnt_t'(N))
					st_c = srt_pkg::ST_FULL;
				else if (ctl.new_end[32])
					st_c = srt_pkg::ST_WRAP;
				else if (|early_v)
					st_c = srt_pkg::ST_OVERLAP;
				else if (|dup_v)
					st_c = srt_pkg::ST_DUPLICATE;
				else if (|later_v)
					st_c = srt_pkg::ST_OVERLAP;
				else begin
					st_c    = srt_pkg::ST_INSERTED;
					ins_ok  = 1'b1;
					count_d = count_q + srt_pkg::cnt_t'(1);
					bytes_d = bytes_q + {6'b0, len_s1};
				end
			end
			srt_pkg::MODE_CLEAR: begin
				st_c    = srt_pkg::ST_CLEARED;
				count_d = '0;
				bytes_d = '0;
			end
			default: begin
				if (|(first_v & gap_v))
					st_c = srt_pkg::ST_GAP;
				else if (|(first_v & covl_v))
					st_c = srt_pkg::ST_CHAIN_OVL;
				else
					st_c = srt_pkg::ST_CONTIG;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= srt_pkg::MAX_LEN_RST;
			valid_s1    <= 1'b0;
			count_q     <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				max_len_q <= cfg_data;
			if (in_valid && !valid_s1)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire) begin
				count_q     <= count_d;
				bytes_q     <= bytes_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !valid_s1) begin
			mode_s1 <= mode;
			seq_s1  <= seq_start;
			len_s1  <= seg_len;
		end
		if (fire) begin
			status_q     <= st_c;
			total_q      <= 6'(count_d);
			byte_total_q <= bytes_d[20:0];
		end
	end

	assign in_stall    = valid_s1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_total = total_q;
	assign byte_total  = byte_total_q;

endmodule

[sv/srt_checker.sv]
module srt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  status,
	input logic [5:0]  entry_total,
	input logic [20:0] byte_total
);

	// one request in flight: stall the next cycle after an accept
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted without stalling the next one");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)
			&& $stable(entry_total) && $stable(byte_total)))
		else $error("stalled result changed");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= srt_pkg::ST_CLEARED))
		else $error("status code out of range");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == srt_pkg::ST_CLEARED) |->
			(entry_total == 6'd0 && byte_total == 21'd0))
		else $error("clear left nonzero totals");

	a_insert_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == srt_pkg::ST_INSERTED) |-> (entry_total != 6'd0))
		else $error("insert reported an empty table");

endmodule

bind segment_reassembly_table srt_checker u_srt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.entry_total (entry_total),
	.byte_total  (byte_total)
);

[bench/testbench.sv]
module testbench;

	import srt_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int NUM_DIRECTED = 24;
	localparam int NUM_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [3:0]  st;
		logic [5:0]  entries;
		logic [20:0] bytes;
	} table_result_t;

	typedef struct packed {
		logic [1:0]    op;
		logic [31:0]   seq;
		logic [15:0]   len;
		logic          known;
		table_result_t res;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_INSERT;
	logic [31:0] seq_start = 32'd0;
	logic [15:0] seg_len = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  status;
	logic [5:0]  entry_total;
	logic [20:0] byte_total;

	segment_reassembly_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.seq_start   (seq_start),
		.seg_len     (seg_len),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_total (entry_total),
		.byte_total  (byte_total)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the segment table
	logic [31:0] held_seq [MAX_ENTRIES];
	logic [15:0] held_len [MAX_ENTRIES];
	int          held_count = 0;
	logic [21:0] held_bytes = 22'd0;
	logic [15:0] limit_len = MAX_LEN_RST;

	table_result_t pending_results [$];
	int            failures = 0;
	int            cycles = 0;
	int            burst_left = 0;
	logic [31:0]   stream_base = 32'd0;
	logic [31:0]   stream_next = 32'd0;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{MODE_CHECK,  32'd0,         16'd0,     1'b1, '{ST_CONTIG,   6'd0, 21'd0}},
		'{MODE_CLEAR,  32'hFFFF_FFFF, 16'hFFFF,  1'b1, '{ST_CLEARED,  6'd0, 21'd0}},
		'{MODE_SPARE,  32'd0,         16'd0,     1'b1, '{ST_CONTIG,   6'd0, 21'd0}},
		'{MODE_INSERT, 32'd1000,      16'd1501,  1'b1, '{ST_TOO_LONG, 6'd0, 21'd0}},
		'{MODE_INSERT, 32'd1000,      16'hFFFF,  1'b1, '{ST_TOO_LONG, 6'd0, 21'd0}},
		'{MODE_INSERT, 32'hFFFF_FFFF, 16'd1,     1'b1, '{ST_WRAP,     6'd0, 21'd0}},
		'{MODE_INSERT, 32'hFFFF_FFFF, 16'd0,     1'b0, '0},
		'{MODE_INSERT, 32'd0,         16'd1500,  1'b0, '0},
		'{MODE_INSERT, 32'd0,         16'd0,     1'b0, '0},
		'{MODE_INSERT, 32'd1600,      16'd100,   1'b0, '0},
		'{MODE_CHECK,  32'd0,         16'd0,     1'b0, '0},
		'{MODE_INSERT, 32'd1500,      16'd100,   1'b0, '0},
		'{MODE_INSERT, 32'd1550,      16'd10,    1'b0, '0},
		'{MODE_INSERT, 32'd1400,      16'd10,    1'b0, '0},
		'{MODE_INSERT, 32'd1700,      16'd50,    1'b0, '0},
		'{MODE_INSERT, 32'd1800,      16'd100,   1'b0, '0},
		'{MODE_INSERT, 32'd1760,      16'd50,    1'b0, '0},
		'{MODE_INSERT, 32'd1750,      16'd50,    1'b0, '0},
		'{MODE_INSERT, 32'd1900,      16'd0,     1'b0, '0},
		'{MODE_INSERT, 32'hFFFF_FA24, 16'd1500,  1'b0, '0},
		'{MODE_INSERT, 32'hFFFF_FA23, 16'd1500,  1'b0, '0},
		'{MODE_SPARE,  32'd0,         16'd0,     1'b0, '0},
		'{MODE_CLEAR,  32'd0,         16'd0,     1'b1, '{ST_CLEARED,  6'd0, 21'd0}},
		'{MODE_CHECK,  32'd0,         16'd0,     1'b1, '{ST_CONTIG,   6'd0, 21'd0}}
	};

	function automatic table_result_t predict_table_op(input logic [1:0] op,
			input logic [31:0] seq, input logic [15:0] len);
		table_result_t r;
		logic [32:0]   new_end;
		logic [32:0]   end_i;
		logic [3:0]    st;
		int            pos;
		new_end = {1'b0, seq} + {17'd0, len};
		pos = held_count;
		st = ST_INSERTED;
		if (op == MODE_INSERT) begin
			if (len > limit_len)
				st = ST_TOO_LONG;
			else if (held_count >= MAX_ENTRIES)
				st = ST_FULL;
			else if (new_end[32])
				st = ST_WRAP;
			else begin
				for (int i = 0; i < held_count; i++) begin
					end_i = {1'b0, held_seq[i]} + {17'd0, held_len[i]};
					if (held_seq[i] == seq) begin
						st = ST_DUPLICATE;
						break;
					end
					if (held_seq[i] < seq) begin
						if (end_i > {1'b0, seq}) begin
							st = ST_OVERLAP;
							break;
						end
					end else begin
						if ({1'b0, held_seq[i]} < new_end)
							st = ST_OVERLAP;
						else
							pos = i;
						break;
					end
				end
				if (st == ST_INSERTED) begin
					for (int k = held_count; k > pos; k--) begin
						held_seq[k] = held_seq[k-1];
						held_len[k] = held_len[k-1];
					end
					held_seq[pos] = seq;
					held_len[pos] = len;
					held_count++;
					held_bytes = held_bytes + {6'd0, len};
				end
			end
		end else if (op == MODE_CLEAR) begin
			held_count = 0;
			held_bytes = 22'd0;
			st = ST_CLEARED;
		end else begin
			// check and the spare mode walk adjacent pairs
			st = ST_CONTIG;
			for (int i = 0; i + 1 < held_count; i++) begin
				end_i = {1'b0, held_seq[i]} + {17'd0, held_len[i]};
				if (end_i < {1'b0, held_seq[i+1]}) begin
					st = ST_GAP;
					break;
				end
				if (end_i > {1'b0, held_seq[i+1]}) begin
					st = ST_CHAIN_OVL;
					break;
				end
			end
		end
		r.st = st;
		r.entries = 6'(held_count);
		r.bytes = held_bytes[20:0];
		return r;
	endfunction

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_request(input logic [1:0] op, input logic [31:0] seq,
			input logic [15:0] len, input logic known, input table_result_t fixed);
		table_result_t predicted;
		pace_sender();
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= op;
		seq_start <= seq;
		seg_len <= len;
		do @(posedge clk); while (in_stall);
		predicted = predict_table_op(op, seq, len);
		pending_results.push_back(known ? fixed : predicted);
	endtask

	// Hold the sender until every pending result is back
	task automatic drain_results();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_limit(input logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk) cfg_we <= 1'b0;
		limit_len = value;
	endtask

	task automatic restart_stream();
		if ($urandom_range(0, 4) == 0)
			stream_base = 32'hFFFF_FFFF - $urandom_range(0, 200000);
		else
			stream_base = $urandom;
		stream_next = stream_base;
	endtask

	// Mostly in-order and out-of-order pieces of one stream, some noise
	task automatic pick_request(output logic [1:0] op, output logic [31:0] seq,
			output logic [15:0] len);
		int roll;
		roll = $urandom_range(0, 99);
		op = MODE_INSERT;
		if (held_count == MAX_ENTRIES && $urandom_range(0, 3) == 0)
			op = MODE_CLEAR;
		else if (roll < 12)
			op = MODE_CHECK;
		else if (roll < 15)
			op = MODE_SPARE;
		else if (roll < 18)
			op = MODE_CLEAR;
		if (op == MODE_CLEAR)
			restart_stream();

		roll = $urandom_range(0, 99);
		if (roll < 70)
			len = 16'($urandom_range(0, limit_len));
		else if (roll < 78)
			len = limit_len;
		else if (roll < 84)
			len = 16'd0;
		else if (roll < 92)
			len = limit_len + 16'd1;
		else
			len = 16'($urandom);

		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			seq = stream_next;
			if (len <= limit_len)
				stream_next = seq + {16'd0, len} +
					(($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 300)) : 32'd0);
		end else if (roll < 65)
			seq = stream_base + $urandom_range(0, stream_next - stream_base);
		else if (roll < 75 && held_count > 0)
			seq = held_seq[$urandom_range(0, held_count - 1)];
		else if (roll < 88)
			seq = $urandom;
		else
			seq = 32'hFFFF_FFFF - $urandom_range(0, 70000);
	endtask

	int stall_kind = 0;
	int stall_left = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_kind = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		case (stall_kind)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 3) == 0);
		2: out_stall <= ($urandom_range(0, 9) < 7);
		default: out_stall <= (stall_left % 11) < 4;
		endcase
	end

	always @(posedge clk) begin : result_check
		table_result_t got;
		table_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, entry_total, byte_total};
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: status %0d entries %0d bytes %0d",
						got.st, got.entries, got.bytes);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("mismatch: status %0d/%0d entries %0d/%0d bytes %0d/%0d",
							want.st, got.st, want.entries, got.entries,
							want.bytes, got.bytes);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [1:0]  op;
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] phase_limit;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].seq, directed_rows[i].len,
				directed_rows[i].known, directed_rows[i].res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
			0: phase_limit = 16'd0;
			1: phase_limit = 16'hFFFF;
			2: phase_limit = 16'd1;
			3: phase_limit = MAX_LEN_RST;
			default: phase_limit = 16'($urandom_range(2, 65534));
			endcase
			write_limit(phase_limit);
			restart_stream();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0)
					drain_results();
				pick_request(op, seq, len);
				send_request(op, seq, len, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
